FILE: rtl/bgr_pkg.sv
// Shared types and constants for the bilevel group row encoder.
package bgr_pkg;

    localparam int MAX_GROUP_DEF = 16;
    localparam int MAX_ROW_BYTES = 8192;
    localparam int WHITE_LIMIT = (MAX_ROW_BYTES < 16383) ? MAX_ROW_BYTES : 16383;

    localparam int SIZE_W = 5;
    localparam int RUN_W = 14;
    localparam int BYTE_W = 8;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    localparam logic [SIZE_W-1:0] GROUP_BYTES_RESET = 5'd4;

    typedef enum logic [1:0] {
        KIND_FLAG = 2'd0,
        KIND_CODE = 2'd1,
        KIND_RAW  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CODE,
        ST_RD,
        ST_RAW,
        ST_FLAG
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic              nonwhite;
        logic [RUN_W-1:0]  run;
        logic              code;
        logic [BYTE_W-1:0] raw;
        logic              last;
    } result_t;

endpackage

FILE: rtl/bgr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bgr_out_reg.sv
// Output register stage that packs one result word onto the master stream.
module bgr_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bgr_pkg::result_t                    in_word,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: row_nonwhite, white_run[13:0], group_code, raw_byte[7:0].
    output logic [bgr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: out_kind[1:0].
    output logic [bgr_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast
);

    import bgr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign in_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {word_reg.raw, word_reg.code, word_reg.run, word_reg.nonwhite};
    assign m_axis_tuser  = word_reg.kind;
    assign m_axis_tlast  = word_reg.last;

endmodule

FILE: rtl/bilevel_group_row_encoder.sv
// Top level of the bilevel group row encoder: byte intake, group sequencer and output.
// A byte that does not close a group is taken while idle; the next byte may follow at once.
// A closing white group emits no word, a black group a code word, and a diff group a code
// word, then per byte a read on the one read port of the group buffer and a raw word.
// A row end adds a row flag word; a result may wait in the output register.
// Reset clears all control and row state and sets the group size to four bytes.
module bilevel_group_row_encoder #(
    parameter int MAX_GROUP = bgr_pkg::MAX_GROUP_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: pixel_byte[7:0].
    input  logic [bgr_pkg::BYTE_W-1:0]          s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: row_nonwhite, white_run[13:0], group_code, raw_byte[7:0].
    output logic [bgr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: out_kind[1:0].
    output logic [bgr_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_wr_en,
    input  logic [bgr_pkg::SIZE_W-1:0]          cfg_wr_data
);

    import bgr_pkg::*;

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   group_bytes_reg;
    logic [SIZE_W-1:0]   fill_reg, fill_next;
    logic                white_reg, white_next;
    logic                black_reg, black_next;
    logic [RUN_W-1:0]    pend_reg, pend_next;
    logic                has_reg, has_next;
    logic                diff_reg, diff_next;
    logic                row_end_reg, row_end_next;
    logic [SIZE_W-1:0]   nbytes_reg, nbytes_next;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;

    logic                accept;
    logic [SIZE_W-1:0]   size_now;
    logic [SIZE_W-1:0]   fill_inc;
    logic                white_upd;
    logic                black_upd;
    logic                group_close;
    logic                raw_final;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                emit_valid;
    logic                emit_ready;
    result_t             emit_word;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign size_now = (group_bytes_reg == '0) ? SIZE_W'(1) :
                      (group_bytes_reg > SIZE_W'(MAX_GROUP)) ? SIZE_W'(MAX_GROUP) :
                      group_bytes_reg;
    assign fill_inc    = fill_reg + SIZE_W'(1);
    assign white_upd   = white_reg && (s_axis_tdata == 8'hFF);
    assign black_upd   = black_reg && (s_axis_tdata == 8'h00);
    assign group_close = (fill_inc >= size_now) || s_axis_tlast;
    assign raw_final   = (SIZE_W'(cnt_reg + SIZE_W'(1)) == nbytes_reg);

    bgr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_GROUP),
        .AW    (AW)
    ) u_group_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (fill_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    bgr_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (emit_valid),
        .in_ready      (emit_ready),
        .in_word       (emit_word),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        white_next   = white_reg;
        black_next   = black_reg;
        pend_next    = pend_reg;
        has_next     = has_reg;
        diff_next    = diff_reg;
        row_end_next = row_end_reg;
        nbytes_next  = nbytes_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (group_close)
                    begin
                        fill_next    = '0;
                        white_next   = 1'b1;
                        black_next   = 1'b1;
                        row_end_next = s_axis_tlast;
                        nbytes_next  = fill_inc;
                        diff_next    = !black_upd;
                        cnt_next     = '0;
                        if (white_upd)
                        begin
                            if (pend_reg < RUN_W'(WHITE_LIMIT))
                            begin
                                pend_next = pend_reg + RUN_W'(1);
                            end
                            state_next = s_axis_tlast ? ST_FLAG : ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_CODE;
                        end
                    end
                    else
                    begin
                        fill_next  = fill_inc;
                        white_next = white_upd;
                        black_next = black_upd;
                    end
                end
            end
            ST_CODE:
            begin
                if (emit_ready)
                begin
                    pend_next = '0;
                    has_next  = 1'b1;
                    if (diff_reg)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = row_end_reg ? ST_FLAG : ST_IDLE;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                if (emit_ready)
                begin
                    cnt_next = cnt_reg + SIZE_W'(1);
                    if (raw_final)
                    begin
                        state_next = row_end_reg ? ST_FLAG : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_FLAG:
            begin
                if (emit_ready)
                begin
                    pend_next  = '0;
                    has_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit_valid = 1'b0;
        emit_word  = '0;
        case (state_reg)
            ST_CODE:
            begin
                emit_valid     = 1'b1;
                emit_word.kind = KIND_CODE;
                emit_word.run  = pend_reg;
                emit_word.code = diff_reg;
                emit_word.last = !diff_reg && !row_end_reg;
            end
            ST_RAW:
            begin
                emit_valid     = 1'b1;
                emit_word.kind = KIND_RAW;
                emit_word.raw  = ram_rdata;
                emit_word.last = raw_final && !row_end_reg;
            end
            ST_FLAG:
            begin
                emit_valid         = 1'b1;
                emit_word.kind     = KIND_FLAG;
                emit_word.nonwhite = has_reg;
                emit_word.run      = has_reg ? pend_reg : '0;
                emit_word.last     = 1'b1;
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            group_bytes_reg <= GROUP_BYTES_RESET;
            fill_reg        <= '0;
            white_reg       <= 1'b1;
            black_reg       <= 1'b1;
            pend_reg        <= '0;
            has_reg         <= 1'b0;
            diff_reg        <= 1'b0;
            row_end_reg     <= 1'b0;
            nbytes_reg      <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            white_reg   <= white_next;
            black_reg   <= black_next;
            pend_reg    <= pend_next;
            has_reg     <= has_next;
            diff_reg    <= diff_next;
            row_end_reg <= row_end_next;
            nbytes_reg  <= nbytes_next;
            cnt_reg     <= cnt_next;
            if (cfg_wr_en)
            begin
                group_bytes_reg <= cfg_wr_data;
            end
        end
    end

    // The open group never holds a full buffer between bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < SIZE_W'(MAX_GROUP))
        else $error("group fill reached the buffer depth");

    // Raw byte reads stay inside the closed group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RAW || state_reg == ST_RD) |-> (cnt_reg < nbytes_reg))
        else $error("raw byte index beyond the closed group");

    // Every row end leads to work that ends in a row flag word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (state_reg != ST_IDLE))
        else $error("row end accepted without a row flag");

    // A row flag word always closes the results of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_FLAG)) |-> m_axis_tlast)
        else $error("row flag word without last mark");

    // No byte is taken while the sequencer still has results of the previous one to emit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CODE || state_reg == ST_RAW || state_reg == ST_FLAG) |-> !s_axis_tready)
        else $error("input ready while results pending");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the bilevel group row encoder with a scoreboard class.
class group_code_board;
    bgr_pkg::result_t expected_codes[$];
    int unsigned mismatches;
    logic [7:0] held [16];
    int unsigned fill;
    bit all_white;
    bit all_black;
    bit row_coded;
    int unsigned white_pending;
    logic [bgr_pkg::SIZE_W-1:0] size_reg;

    function new();
        mismatches = 0;
        size_reg = bgr_pkg::GROUP_BYTES_RESET;
        white_pending = 0;
        row_coded = 1'b0;
        clear_group();
    endfunction

    function void clear_group();
        fill = 0;
        all_white = 1'b1;
        all_black = 1'b1;
    endfunction

    function int waiting();
        return expected_codes.size();
    endfunction

    function bgr_pkg::result_t word_of(bgr_pkg::kind_t kind, logic nonwhite,
                                       int unsigned run, logic code, logic [7:0] raw);
        bgr_pkg::result_t w;
        w.kind = kind;
        w.nonwhite = nonwhite;
        w.run = run[bgr_pkg::RUN_W-1:0];
        w.code = code;
        w.raw = raw;
        w.last = 1'b0;
        return w;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        bgr_pkg::result_t produced[$];
        int unsigned width;
        if (fill < 16)
        begin
            held[fill] = b;
            fill++;
        end
        if (b != 8'hFF)
            all_white = 1'b0;
        if (b != 8'h00)
            all_black = 1'b0;
        width = (size_reg == 0) ? 1 : size_reg;
        if (width > bgr_pkg::MAX_GROUP_DEF)
            width = bgr_pkg::MAX_GROUP_DEF;
        if (fill >= width || last)
        begin
            if (all_white)
            begin
                if (white_pending < bgr_pkg::WHITE_LIMIT)
                    white_pending++;
            end
            else
            begin
                produced.push_back(word_of(bgr_pkg::KIND_CODE, 1'b0, white_pending,
                                           !all_black, 8'h00));
                white_pending = 0;
                row_coded = 1'b1;
                if (!all_black)
                begin
                    for (int i = 0; i < fill; i++)
                        produced.push_back(word_of(bgr_pkg::KIND_RAW, 1'b0, 0, 1'b0, held[i]));
                end
            end
            clear_group();
        end
        if (last)
        begin
            produced.push_back(word_of(bgr_pkg::KIND_FLAG, row_coded,
                                       row_coded ? white_pending : 0, 1'b0, 8'h00));
            white_pending = 0;
            row_coded = 1'b0;
        end
        if (produced.size() > 0)
            produced[produced.size()-1].last = 1'b1;
        foreach (produced[i])
            expected_codes.push_back(produced[i]);
    endfunction

    function int compare_field(string field, logic [13:0] want, logic [13:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    function void check_word(bgr_pkg::result_t got);
        bgr_pkg::result_t want;
        if (expected_codes.size() == 0)
        begin
            $error("word with no expectation: out_kind %0d, white_run %0d, raw_byte %0d",
                   got.kind, got.run, got.raw);
            mismatches++;
            return;
        end
        want = expected_codes.pop_front();
        mismatches += compare_field("out_kind", 14'(want.kind), 14'(got.kind));
        mismatches += compare_field("row_nonwhite", 14'(want.nonwhite), 14'(got.nonwhite));
        mismatches += compare_field("white_run", want.run, got.run);
        mismatches += compare_field("group_code", 14'(want.code), 14'(got.code));
        mismatches += compare_field("raw_byte", 14'(want.raw), 14'(got.raw));
        mismatches += compare_field("last_result", 14'(want.last), 14'(got.last));
    endfunction
endclass

module tb;
    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [bgr_pkg::BYTE_W-1:0]       s_axis_tdata;
    logic                             s_axis_tlast;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [bgr_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic [bgr_pkg::OUT_USER_W-1:0]   m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             cfg_wr_en;
    logic [bgr_pkg::SIZE_W-1:0]       cfg_wr_data;

    group_code_board board;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned bytes_sent;
    logic [bgr_pkg::SIZE_W-1:0] group_bytes_now;

    bilevel_group_row_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    initial
    begin : monitor
        bgr_pkg::result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.kind = bgr_pkg::kind_t'(m_axis_tuser);
                got.nonwhite = m_axis_tdata[0];
                got.run = m_axis_tdata[14:1];
                got.code = m_axis_tdata[15];
                got.raw = m_axis_tdata[23:16];
                got.last = m_axis_tlast;
                board.check_word(got);
            end
        end
    end

    initial
    begin
        #(12 * 600000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_byte(b, last);
    endtask

    // The pause covers a white group that closes with no word to show for it.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_group_bytes(input logic [bgr_pkg::SIZE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.size_reg = value;
        group_bytes_now = value;
    endtask

    task automatic send_random_row();
        int unsigned width;
        int unsigned groups;
        int unsigned len;
        int unsigned pick;
        int unsigned flip;
        logic [7:0] b;
        width = (group_bytes_now == 0) ? 1 : group_bytes_now;
        if (width > bgr_pkg::MAX_GROUP_DEF)
            width = bgr_pkg::MAX_GROUP_DEF;
        groups = $urandom_range(1, 48 / width + 1);
        for (int gi = 0; gi < groups; gi++)
        begin
            len = width;
            if (gi == groups - 1 && $urandom_range(0, 2) == 0)
                len = $urandom_range(1, width);
            pick = $urandom_range(0, 9);
            flip = $urandom_range(0, len - 1);
            for (int k = 0; k < len; k++)
            begin
                case (pick)
                    0, 1, 2, 3: b = 8'hFF;
                    4, 5: b = 8'h00;
                    6, 7, 8: b = 8'($urandom_range(0, 255));
                    default: b = (k == flip) ? 8'($urandom_range(0, 255))
                                             : (flip[0] ? 8'hFF : 8'h00);
                endcase
                send_word(b, (gi == groups - 1) && (k == len - 1));
                bytes_sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [bgr_pkg::SIZE_W-1:0] phase_size [4];
        int unsigned goal;
        board = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        group_bytes_now = bgr_pkg::GROUP_BYTES_RESET;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset group size: white, black, diff, then a short white group at row end.
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hFF, 1'b1);
        // An all-white row, then a row of one short black group.
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);

        // Shrinking the group size below the open fill closes the group on the next byte.
        settle();
        set_group_bytes(5'd8);
        send_word(8'h01, 1'b0);
        send_word(8'h02, 1'b0);
        send_word(8'h03, 1'b0);
        settle();
        set_group_bytes(5'd2);
        send_word(8'h04, 1'b0);
        send_word(8'h00, 1'b1);

        // A size of zero acts as one byte per group.
        settle();
        set_group_bytes(5'd0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h5A, 1'b1);

        // A run of white groups carried onto the next group code.
        settle();
        set_group_bytes(5'd1);
        send_word(8'h00, 1'b0);
        repeat (20) send_word(8'hFF, 1'b0);
        send_word(8'h3C, 1'b1);

        phase_size[0] = 5'd16;
        phase_size[1] = 5'd1;
        phase_size[2] = 5'($urandom_range(2, 6));
        phase_size[3] = 5'd31;
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            set_group_bytes(phase_size[phase]);
            send_idle_pct = (phase == 1) ? 54 : (phase == 3) ? 8 : 0;
            recv_stall_pct = (phase == 2) ? 54 : (phase == 3) ? 8 : 0;
            goal = bytes_sent + 50;
            while (bytes_sent < goal)
                send_random_row();
        end

        settle();
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
